FILE: design/allpass_bandpass_biquad_macros.svh
// Assertion macros shared by the bandpass filter checkers.
`ifndef ALLPASS_BANDPASS_BIQUAD_MACROS_SVH
`define ALLPASS_BANDPASS_BIQUAD_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define APBQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define APBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/apbq_pkg.sv
// Package: constants, codes and types of the allpass-based bandpass biquad.
package apbq_pkg;

  // Default widths
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  // Accumulator wraps modulo 2^64
  localparam int ACC_W              = 64;
  localparam int CFG_IDX_W          = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BANDWIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER    = 2'd1;

  // Coefficient reset values (Q2.14)
  localparam logic signed [15:0] BANDWIDTH_COEF_RST = -16'sd15924;
  localparam logic signed [15:0] CENTER_COEF_RST    = -16'sd15723;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_DY1,
    ST_MUL_B,
    ST_MUL_C,
    ST_ACC_C,
    ST_ROUND
  } seq_state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_A_TERM,   // (one+c) * (x - x2)
    MUL_D_Y1,     // d * y1
    MUL_B_TERM,   // (one-c) * (d*y1)
    MUL_C_TERM    // c * y2
  } mul_op_t;

  // Accumulator update
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_A,
    ACC_SUB_B,
    ACC_ADD_C
  } acc_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    mul_en;
    acc_op_t acc_op;
    logic    commit;
  } apbq_ctrl_t;

  typedef struct packed {
    logic start;
    logic warm;
    logic out_free;
  } apbq_stat_t;

endpackage

FILE: design/apbq_if.sv
// Handshake interfaces: input word, result word and register write channel.
interface apbq_in_if import apbq_pkg::*; #(
  parameter int W = SAMPLE_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, sample_in, input ready);
  modport sink   (input valid, sample_in, output ready);
endinterface

interface apbq_out_if import apbq_pkg::*; #(
  parameter int W = SAMPLE_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface apbq_cfg_if import apbq_pkg::*; #(
  parameter int DW = COEF_FRAC_BITS_DEF + 2
);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DW-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/apbq_mul.sv
// Shared signed multiplier with registered product, wrapped to the accumulator width.
module apbq_mul import apbq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic signed [COEF_FRAC_BITS+2:0]              op_a,
  input  logic signed [SAMPLE_WIDTH+COEF_FRAC_BITS+1:0] op_b,
  output logic signed [ACC_W-1:0]                       prod_r
);

  localparam int AW = COEF_FRAC_BITS + 3;
  localparam int BW = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
  localparam int PW = AW + BW;

  logic signed [PW-1:0]       prod_full;
  logic signed [ACC_W+PW-1:0] prod_ext;

  // Full product, sign-extended then cut to the accumulator width
  always_comb begin
    prod_full = op_a * op_b;
    prod_ext  = (ACC_W+PW)'(prod_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_ext[ACC_W-1:0];
    end
  end

endmodule

FILE: design/apbq_ctrl.sv
// Sequencer: steps the shared multiplier and accumulator through one sample.
module apbq_ctrl import apbq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  apbq_stat_t stat,
  output logic       in_ready,
  output apbq_ctrl_t ctrl
);

  seq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and step controls
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    ctrl.mul_op = MUL_A_TERM;
    ctrl.mul_en = 1'b0;
    ctrl.acc_op = ACC_HOLD;
    ctrl.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (stat.start) begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        ctrl.mul_op = MUL_A_TERM;
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_MUL_DY1;
      end
      ST_MUL_DY1: begin
        ctrl.acc_op = ACC_LOAD_A;
        ctrl.mul_op = MUL_D_Y1;
        ctrl.mul_en = 1'b1;
        // warm-up keeps only the direct input term
        state_nxt   = stat.warm ? ST_ROUND : ST_MUL_B;
      end
      ST_MUL_B: begin
        ctrl.mul_op = MUL_B_TERM;
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_MUL_C;
      end
      ST_MUL_C: begin
        ctrl.acc_op = ACC_SUB_B;
        ctrl.mul_op = MUL_C_TERM;
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_ACC_C;
      end
      ST_ACC_C: begin
        ctrl.acc_op = ACC_ADD_C;
        state_nxt   = ST_ROUND;
      end
      ST_ROUND: begin
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/allpass_bandpass_biquad.sv
// Top level: allpass-based second-order bandpass filter with one shared multiplier.
//
// Channels: in_ch takes one signed audio sample per word, out_ch gives one
// filtered, saturated sample per word, cfg_ch writes the coefficient
// registers (index 0: bandwidth c, index 1: center d, both signed Q2.F).
// cfg_ch is always ready; write it only while no sample is in flight.
// Timing: a sample runs through four multiplies on one multiplier, each
// product registered before it is accumulated, then one round/saturate
// step; the two warm-up samples after reset keep only the input term and
// skip the last two multiplies. The result word becomes valid and in_ch is
// ready again in the same cycle, so a new sample is taken only after the
// last one's result is committed.
// Reset (rst_n low, synchronous) clears the delay lines and the warm-up
// count, loads the default coefficients and empties the result register.
// A stalled receiver holds the result word; the next sample is still taken
// and computed, and waits in the round step until the result register frees.
module allpass_bandpass_biquad import apbq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  apbq_in_if.sink     in_ch,
  apbq_out_if.source  out_ch,
  apbq_cfg_if.sink    cfg_ch
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int AW = CW + 1;
  localparam int BW = W + CW;

  localparam logic signed [AW-1:0]    ONE_A  = AW'(1) << F;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (2 * F);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // Coefficients, sample and state
  logic signed [CW-1:0]    bw_coef_r, ctr_coef_r;
  logic signed [W-1:0]     x_r;
  logic signed [W-1:0]     xd1_r, xd2_r, yd1_r, yd2_r;
  logic [1:0]              warm_cnt_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r;
  logic signed [W-1:0]     out_data_r;

  logic                    in_ready;
  apbq_ctrl_t              ctrl;
  apbq_stat_t              stat;
  logic signed [AW-1:0]    c_ext, d_ext, one_plus_c, one_minus_c;
  logic signed [W:0]       diff;
  logic signed [AW-1:0]    op_a;
  logic signed [BW-1:0]    op_b;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_rnd, acc_shr;
  logic signed [W-1:0]     y;

  assign in_ch.ready    = in_ready;
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  assign stat.start    = in_ch.valid && in_ready;
  assign stat.warm     = (warm_cnt_r < 2'd2);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  apbq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    c_ext       = AW'(bw_coef_r);
    d_ext       = AW'(ctr_coef_r);
    one_plus_c  = ONE_A + c_ext;
    one_minus_c = ONE_A - c_ext;
    diff        = stat.warm ? (W+1)'(x_r) : (W+1)'(x_r) - (W+1)'(xd2_r);
    case (ctrl.mul_op)
      MUL_A_TERM: begin
        op_a = one_plus_c;
        op_b = BW'(diff);
      end
      MUL_D_Y1: begin
        op_a = d_ext;
        op_b = BW'(yd1_r);
      end
      MUL_B_TERM: begin
        op_a = one_minus_c;
        op_b = $signed(prod_r[BW-1:0]);
      end
      MUL_C_TERM: begin
        op_a = c_ext;
        op_b = BW'(yd2_r);
      end
      default: begin
        op_a = one_plus_c;
        op_b = BW'(diff);
      end
    endcase
  end

  apbq_mul #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Accumulator update from the registered product
  always_comb begin
    case (ctrl.acc_op)
      ACC_HOLD:   acc_nxt = acc_r;
      ACC_LOAD_A: acc_nxt = prod_r <<< F;
      ACC_SUB_B:  acc_nxt = acc_r - (prod_r <<< 1);
      ACC_ADD_C:  acc_nxt = acc_r + (prod_r <<< (F + 1));
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Round half up, drop 2F+1 fraction bits, saturate
  always_comb begin
    acc_rnd = acc_r + RND;
    acc_shr = acc_rnd >>> (2 * F + 1);
    if (acc_shr > SAT_HI) begin
      y = W'(SAT_HI);
    end else if (acc_shr < SAT_LO) begin
      y = W'(SAT_LO);
    end else begin
      y = W'(acc_shr);
    end
  end

  // Input word capture
  always_ff @(posedge clk) begin
    if (stat.start) begin
      x_r <= in_ch.sample_in;
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_coef_r  <= CW'(BANDWIDTH_COEF_RST);
      ctr_coef_r <= CW'(CENTER_COEF_RST);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_IDX_BANDWIDTH) begin
        bw_coef_r <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_IDX_CENTER) begin
        ctr_coef_r <= cfg_ch.data;
      end
    end
  end

  // Delay lines and warm-up count advance when a result is committed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xd1_r      <= '0;
      xd2_r      <= '0;
      yd1_r      <= '0;
      yd2_r      <= '0;
      warm_cnt_r <= '0;
    end else if (ctrl.commit) begin
      xd2_r <= xd1_r;
      xd1_r <= x_r;
      yd2_r <= yd1_r;
      yd1_r <= y;
      if (stat.warm) begin
        warm_cnt_r <= warm_cnt_r + 2'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data_r <= y;
    end
  end

endmodule

FILE: design/apbq_checker.sv
// Port checker for the bandpass biquad and its bind to the top level.
`include "allpass_bandpass_biquad_macros.svh"

module apbq_checker import apbq_pkg::*; #(
  parameter int W = SAMPLE_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_data
);

  // Result word holds while the receiver stalls
  `APBQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `APBQ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result word changed while stalled")

  // One sample at a time: busy right after taking a word
  `APBQ_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "input taken while busy")

  // A fresh result follows a taken word by the full or the warm-up latency
  `APBQ_ASSERT_NOW(a_result_latency, $rose(out_valid), $past(in_valid && in_ready, 7) || $past(in_valid && in_ready, 4), "result without matching input word")

endmodule

bind allpass_bandpass_biquad apbq_checker #(
  .W (SAMPLE_WIDTH)
) u_apbq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out)
);
